/* hw/rtl/mimc_pkg.sv */
// shared types and constants for the mimc cube permutation block
package mimc_pkg;

	// fixed widths of the stream fields
	localparam int FIELD_BITS   = 64;
	localparam int SLOT_W       = 6;
	localparam int RCOUNT_W     = 7;
	localparam int IN_TDATA_W   = 72;
	localparam int OUT_TDATA_W  = 136;

	// bits of the multiplier operand consumed per cycle
	localparam int DIGIT        = 4;

	// configuration reset values
	localparam logic [FIELD_BITS-1:0] POLY_RESET   = 64'd27;
	localparam logic [RCOUNT_W-1:0]   RCOUNT_RESET = 7'd41;

	// configuration register indexes
	typedef enum logic {
		REG_POLY   = 1'b0,
		REG_ROUNDS = 1'b1
	} cfg_reg_t;

	// input item kinds
	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EVAL = 1'b1
	} item_mode_t;

	// round sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_XOR,
		ST_SQUARE,
		ST_CUBE,
		ST_EMIT
	} mimc_state_t;

	// multiplier status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} gfm_stat_t;

endpackage

/* hw/rtl/mimc_gfmul.sv */
// digit-serial multiplier in GF(2^WIDTH), msb first, DIGIT bits per cycle
module mimc_gfmul import mimc_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] poly,
	output logic [WIDTH-1:0] product,
	output gfm_stat_t        stat
);

	localparam int NSTEP = (WIDTH + DIGIT - 1) / DIGIT;
	localparam int BW    = NSTEP * DIGIT;
	localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

	logic [WIDTH-1:0] a_q;
	logic [BW-1:0]    b_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] acc_n;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             last_step;

	// one digit of shift-and-reduce
	always_comb begin
		acc_n = acc_q;
		for (int i = 0; i < DIGIT; i++) begin
			if (acc_n[WIDTH-1]) begin
				acc_n = (acc_n << 1) ^ poly;
			end else begin
				acc_n = acc_n << 1;
			end
			if (b_q[BW-1-i]) begin
				acc_n = acc_n ^ a_q;
			end
		end
	end

	assign last_step = (cnt_q == CNT_W'(NSTEP - 1));

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// operand and accumulator registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << DIGIT;
			acc_q <= acc_n;
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/mimc_cube_permutation_gf2n.sv */
// MiMC cube permutation over GF(2^WIDTH): load round constants, evaluate rounds
// sequence: a load writes its slot of the constant table; an evaluation gives one result per round,
// each round stepping through fetch, xor, square, cube and emit, plus output stall
// items: one at a time, no new item accepted until the last round is emitted;
// the shared digit-serial multiplier does two dependent products per round
// reset: sequencer idle, modulus 27, round count 41; constant table not cleared
module mimc_cube_permutation_gf2n import mimc_pkg::*; #(
	parameter int WIDTH      = 64,
	parameter int MAX_ROUNDS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // round_slot[5:0], value[69:6], zero pad
	input  logic [0:0]             s_tuser,   // mode[0]
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // round_number[5:0], square_value[69:6],
	                                          // cube_value[133:70], zero pad
	output logic                   m_tlast,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [FIELD_BITS-1:0]  cfg_data
);

	localparam int ADDR_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
	localparam logic [RCOUNT_W-1:0] MAX_R = RCOUNT_W'(MAX_ROUNDS);

	mimc_state_t state_q, state_d;

	logic [WIDTH-1:0]      const_mem [MAX_ROUNDS];
	logic [WIDTH-1:0]      const_q;
	logic [FIELD_BITS-1:0] poly_q;
	logic [RCOUNT_W-1:0]   rcount_q;
	logic [ADDR_W-1:0]     rnd_q;
	logic [ADDR_W-1:0]     last_q;
	logic [WIDTH-1:0]      x_q;
	logic [WIDTH-1:0]      t_q;
	logic [WIDTH-1:0]      y_q;
	logic                  out_valid_q;
	logic [SLOT_W-1:0]     out_rnd_q;
	logic [FIELD_BITS-1:0] out_sq_q;
	logic [FIELD_BITS-1:0] out_cu_q;
	logic                  out_last_q;

	logic                  s_acc;
	item_mode_t            in_mode;
	logic [SLOT_W-1:0]     in_slot;
	logic [FIELD_BITS-1:0] in_value;
	logic [WIDTH-1:0]      t_x;
	logic [RCOUNT_W-1:0]   rounds_sat;
	logic [RCOUNT_W-1:0]   last_idx;
	logic                  out_load;
	logic                  mul_start;
	logic [WIDTH-1:0]      mul_a;
	logic [WIDTH-1:0]      mul_b;
	logic [WIDTH-1:0]      mul_p;
	gfm_stat_t             mul_stat;

	// input field unpacking
	assign in_mode  = item_mode_t'(s_tuser[0]);
	assign in_slot  = s_tdata[SLOT_W-1:0];
	assign in_value = s_tdata[SLOT_W +: FIELD_BITS];
	assign s_acc    = s_tvalid && s_tready;
	assign t_x      = x_q ^ const_q;

	// round count clamped to 1..MAX_ROUNDS
	always_comb begin
		priority if (rcount_q == '0) begin
			rounds_sat = RCOUNT_W'(1);
		end else if (rcount_q > MAX_R) begin
			rounds_sat = MAX_R;
		end else begin
			rounds_sat = rcount_q;
		end
		last_idx = rounds_sat - RCOUNT_W'(1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && in_mode == MODE_EVAL) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH:  state_d = ST_XOR;
			ST_XOR:    state_d = ST_SQUARE;
			ST_SQUARE: begin
				if (mul_stat.done) begin
					state_d = ST_CUBE;
				end
			end
			ST_CUBE: begin
				if (mul_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = (rnd_q == last_q) ? ST_IDLE : ST_FETCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		mul_start = 1'b0;
		mul_a     = t_q;
		mul_b     = mul_p;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_FETCH:  ;
			ST_XOR: begin
				mul_start = 1'b1;
				mul_a     = t_x;
				mul_b     = t_x;
			end
			ST_SQUARE: mul_start = mul_stat.done;
			ST_CUBE:   ;
			ST_EMIT:   out_load = !out_valid_q || m_tready;
			default:   ;
		endcase
	end

	// shared field multiplier
	mimc_gfmul #(
		.WIDTH (WIDTH)
	) u_gfmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.poly    (poly_q[WIDTH-1:0]),
		.product (mul_p),
		.stat    (mul_stat)
	);

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			poly_q      <= POLY_RESET;
			rcount_q    <= RCOUNT_RESET;
			rnd_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_POLY:   poly_q   <= cfg_data;
					REG_ROUNDS: rcount_q <= cfg_data[RCOUNT_W-1:0];
					default:    ;
				endcase
			end
			if (state_q == ST_IDLE && s_acc && in_mode == MODE_EVAL) begin
				rnd_q  <= '0;
				last_q <= last_idx[ADDR_W-1:0];
			end else if (out_load && rnd_q != last_q) begin
				rnd_q <= rnd_q + ADDR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// round constant table, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc && in_mode == MODE_LOAD
		    && RCOUNT_W'(in_slot) < MAX_R) begin
			const_mem[in_slot[ADDR_W-1:0]] <= in_value[WIDTH-1:0];
		end
		if (state_q == ST_FETCH) begin
			const_q <= const_mem[rnd_q];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc && in_mode == MODE_EVAL) begin
			x_q <= in_value[WIDTH-1:0];
		end
		if (state_q == ST_XOR) begin
			t_q <= t_x;
		end
		if (state_q == ST_SQUARE && mul_stat.done) begin
			y_q <= mul_p;
		end
		if (state_q == ST_CUBE && mul_stat.done) begin
			x_q <= mul_p;
		end
		if (out_load) begin
			out_rnd_q  <= SLOT_W'(rnd_q);
			out_sq_q   <= FIELD_BITS'(y_q);
			out_cu_q   <= FIELD_BITS'(x_q);
			out_last_q <= (rnd_q == last_q);
		end
	end

	// output packing
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_TDATA_W'({out_cu_q, out_sq_q, out_rnd_q});
	assign m_tlast   = out_last_q;
	assign cfg_ready = 1'b1;

	// no new item while a product is in flight
	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mul_stat.busy)
		else $error("input ready while multiplier busy");

	// products finish only where the sequencer waits for them
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_SQUARE || state_q == ST_CUBE))
		else $error("multiplier done outside a product state");

	// the final round hands control back to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && rnd_q == last_q) |=> (state_q == ST_IDLE && out_last_q))
		else $error("final round did not return to idle");

	// round index never passes the clamped count
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rnd_q <= last_q))
		else $error("round index beyond last round");

endmodule
